// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/bmhe_pkg.sv =====
`default_nettype none
package bmhe_pkg;

    localparam int MAP_ENTRIES_DEF = 256;

    // operations
    localparam logic [1:0] OP_EVENT = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_AGG   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ERR = 2'd1;
    localparam logic [1:0] ST_REJ = 2'd2;

    // config register indexes
    localparam logic [2:0] REG_HOST0 = 3'd0;
    localparam logic [2:0] REG_HOST1 = 3'd1;
    localparam logic [2:0] REG_HOST2 = 3'd2;
    localparam logic [2:0] REG_HOST3 = 3'd3;
    localparam logic [2:0] REG_SEAL  = 3'd4;

    typedef enum logic [1:0] {
        BLK_HOST_UPD = 2'd0,
        BLK_PAD      = 2'd1,
        BLK_MEAS_DIG = 2'd2
    } blk_sel_t;

    typedef struct packed {
        logic       item_ld;
        logic       pid_ld;
        logic       hash_start;
        logic       h_iv;
        blk_sel_t   blk_sel;
        logic       upd_zero;
        logic       hreg_ld;
        logic       meas_ld;
        logic       srch_clr;
        logic       srch_rd;
        logic       srch_inc;
        logic       store_en;
        logic       store_valid;
        logic       traj_inc;
        logic       res_ld;
        logic       res_added;
        logic       res_disc;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       seal;
        logic       srch_end;
        logic       match;
        logic       hit_valid;
        logic       full;
        logic       sha_done;
    } status_t;

endpackage
`default_nettype wire

// ===== src/bmhe_sha_core.sv =====
`default_nettype none
// One SHA-256 compression, one round per clock.
module bmhe_sha_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [255:0] h_in,
    input  wire logic [511:0] blk,
    output logic              done,
    output logic [255:0]      h_out
);
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  rnd_reg;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_new;
    logic [255:0] hb_reg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        logic [31:0] t1;
        logic [31:0] t2;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + SHA_K[rnd_reg] + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + t2;
        w_new = w_reg[0]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[9]
              + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hb_reg <= h_in;
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_in[255 - 32*i -: 32];
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk[511 - 32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= v_next[i];
            end
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_out[255 - 32*i -: 32] = hb_reg[255 - 32*i -: 32] + v_reg[i];
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

// ===== src/bmhe_datapath.sv =====
`default_nettype none
// Point table, search pointer, hash chaining, measurement and result registers.
module bmhe_datapath #(
    parameter int MAP_ENTRIES = bmhe_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bmhe_pkg::cmd_t  cmd,
    output bmhe_pkg::status_t    sts,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    input  wire logic [1:0]      op,
    input  wire logic [63:0]     point_w0,
    input  wire logic [63:0]     point_w1,
    input  wire logic [63:0]     point_w2,
    input  wire logic [63:0]     point_w3,
    input  wire logic [21:0]     proc_id,
    output logic                 added,
    output logic                 discipline_flag,
    output logic [1:0]           status_code,
    output logic [63:0]          measure_w0,
    output logic [63:0]          measure_w1,
    output logic [63:0]          measure_w2,
    output logic [63:0]          measure_w3,
    output logic [21:0]          last_proc_id,
    output logic [8:0]           trajectory_len
);
    import bmhe_pkg::*;

    localparam int CW = $clog2(MAP_ENTRIES + 1);
    localparam int IW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [511:0] SHA_PAD = {32'h80000000, 448'd0, 32'd512};

    logic [1:0]    op_reg;
    logic [255:0]  pt_reg;
    logic [21:0]   pid_in_reg;
    logic [255:0]  host_reg;
    logic          seal_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] sidx_reg;
    logic [256:0]  rd_reg;
    logic [255:0]  meas_reg;
    logic [255:0]  hreg_reg;
    logic [21:0]   pid_reg;
    logic [8:0]    traj_reg;
    logic          res_added_reg;
    logic          res_disc_reg;
    logic [1:0]    res_status_reg;
    logic [256:0]  mem [MAP_ENTRIES];

    logic [255:0]  upd;
    logic [511:0]  blk;
    logic [255:0]  h_in;
    logic [255:0]  h_out;
    logic          sha_done;

    assign upd  = cmd.upd_zero ? 256'd0 : pt_reg;
    assign h_in = cmd.h_iv ? SHA_IV : hreg_reg;

    always_comb
    begin
        unique case (cmd.blk_sel)
            BLK_HOST_UPD: blk = {host_reg, upd};
            BLK_MEAS_DIG: blk = {meas_reg, hreg_reg};
            default:      blk = SHA_PAD;
        endcase
    end

    bmhe_sha_core u_sha (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.hash_start),
        .h_in  (h_in),
        .blk   (blk),
        .done  (sha_done),
        .h_out (h_out)
    );

    // item latch, table memory, read, hash and result registers (no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.item_ld)
        begin
            op_reg     <= op;
            pt_reg     <= {point_w0, point_w1, point_w2, point_w3};
            pid_in_reg <= proc_id;
        end
        if (cmd.store_en)
        begin
            mem[count_reg[IW-1:0]] <= {cmd.store_valid, pt_reg};
        end
        if (cmd.srch_rd)
        begin
            rd_reg <= mem[sidx_reg[IW-1:0]];
        end
        if (cmd.hreg_ld)
        begin
            hreg_reg <= h_out;
        end
        if (cmd.res_ld)
        begin
            res_added_reg  <= cmd.res_added;
            res_disc_reg   <= cmd.res_disc;
            res_status_reg <= cmd.res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg  <= '0;
            seal_reg  <= 1'b0;
            count_reg <= '0;
            sidx_reg  <= '0;
            meas_reg  <= '0;
            pid_reg   <= '0;
            traj_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_HOST0: host_reg[255:192] <= cfg_data;
                    REG_HOST1: host_reg[191:128] <= cfg_data;
                    REG_HOST2: host_reg[127:64]  <= cfg_data;
                    REG_HOST3: host_reg[63:0]    <= cfg_data;
                    REG_SEAL:  seal_reg          <= cfg_data[0];
                    default:   ;
                endcase
            end
            if (cmd.store_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.srch_clr)
            begin
                sidx_reg <= '0;
            end
            else if (cmd.srch_inc)
            begin
                sidx_reg <= sidx_reg + 1'b1;
            end
            if (cmd.meas_ld)
            begin
                meas_reg <= h_out;
            end
            if (cmd.pid_ld)
            begin
                pid_reg <= pid_in_reg;
            end
            if (cmd.traj_inc && traj_reg != 9'h1ff)
            begin
                traj_reg <= traj_reg + 9'd1;
            end
        end
    end

    assign sts.op        = op_reg;
    assign sts.seal      = seal_reg;
    assign sts.srch_end  = (sidx_reg >= count_reg);
    assign sts.match     = (rd_reg[255:0] == pt_reg);
    assign sts.hit_valid = rd_reg[256];
    assign sts.full      = (count_reg >= CW'(MAP_ENTRIES));
    assign sts.sha_done  = sha_done;

    assign added           = res_added_reg;
    assign discipline_flag = res_disc_reg;
    assign status_code     = res_status_reg;
    assign measure_w0      = meas_reg[255:192];
    assign measure_w1      = meas_reg[191:128];
    assign measure_w2      = meas_reg[127:64];
    assign measure_w3      = meas_reg[63:0];
    assign last_proc_id    = pid_reg;
    assign trajectory_len  = traj_reg;
endmodule
`default_nettype wire

// ===== src/bmhe_ctrl.sv =====
`default_nettype none
// Sequencer: decode, table search, four-compression extend, result handoff.
module bmhe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire bmhe_pkg::status_t sts,
    output bmhe_pkg::cmd_t         cmd
);
    import bmhe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DEC    = 7'b0000010,
        S_HSTART = 7'b0000100,
        S_HWAIT  = 7'b0001000,
        S_SRD    = 7'b0010000,
        S_SCMP   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        PH_ZERO  = 2'd0,
        PH_AGG   = 2'd1,
        PH_POINT = 2'd2
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] hstep_reg, hstep_next;
    logic       have_agg_reg, have_agg_next;
    logic       poison_reg, poison_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        hstep_next    = hstep_reg;
        have_agg_next = have_agg_reg;
        poison_next   = poison_reg;
        cmd           = '0;
        cmd.blk_sel   = BLK_PAD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_ld = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                priority if (sts.op == OP_NONE || poison_reg)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_ERR;
                    state_next     = S_OUT;
                end
                else if (sts.op == OP_EVENT)
                begin
                    cmd.pid_ld = 1'b1;
                    if (!have_agg_reg)
                    begin
                        phase_next = PH_ZERO;
                        hstep_next = 2'd0;
                        state_next = S_HSTART;
                    end
                    else
                    begin
                        cmd.srch_clr = 1'b1;
                        state_next   = S_SRD;
                    end
                end
                else if (sts.op == OP_LOAD)
                begin
                    if (sts.seal)
                    begin
                        cmd.res_ld     = 1'b1;
                        cmd.res_status = ST_REJ;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.srch_clr = 1'b1;
                        state_next   = S_SRD;
                    end
                end
                else
                begin
                    if (have_agg_reg)
                    begin
                        cmd.res_ld = 1'b1;
                        if (!sts.seal)
                        begin
                            poison_next    = 1'b1;
                            cmd.res_status = ST_ERR;
                        end
                        else
                        begin
                            cmd.res_status = ST_OK;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        phase_next = PH_AGG;
                        hstep_next = 2'd0;
                        state_next = S_HSTART;
                    end
                end
            end
            S_HSTART:
            begin
                cmd.hash_start = 1'b1;
                cmd.h_iv       = !hstep_reg[0];
                cmd.upd_zero   = (phase_reg == PH_ZERO);
                if (hstep_reg == 2'd0)
                begin
                    cmd.blk_sel = BLK_HOST_UPD;
                end
                else if (hstep_reg == 2'd2)
                begin
                    cmd.blk_sel = BLK_MEAS_DIG;
                end
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (sts.sha_done)
                begin
                    cmd.hreg_ld = 1'b1;
                    if (hstep_reg == 2'd3)
                    begin
                        cmd.meas_ld = 1'b1;
                        unique case (phase_reg)
                            PH_ZERO:
                            begin
                                have_agg_next = 1'b1;
                                cmd.srch_clr  = 1'b1;
                                state_next    = S_SRD;
                            end
                            PH_AGG:
                            begin
                                have_agg_next  = 1'b1;
                                cmd.res_ld     = 1'b1;
                                cmd.res_status = ST_OK;
                                state_next     = S_OUT;
                            end
                            default:
                            begin
                                cmd.store_en    = 1'b1;
                                cmd.store_valid = !(sts.op == OP_EVENT && sts.seal);
                                cmd.traj_inc    = (sts.op == OP_EVENT) && !sts.seal;
                                cmd.res_ld      = 1'b1;
                                cmd.res_added   = 1'b1;
                                cmd.res_disc    = (sts.op == OP_EVENT) && sts.seal;
                                cmd.res_status  = ST_OK;
                                state_next      = S_OUT;
                            end
                        endcase
                    end
                    else
                    begin
                        hstep_next = hstep_reg + 2'd1;
                        state_next = S_HSTART;
                    end
                end
            end
            S_SRD:
            begin
                if (sts.srch_end)
                begin
                    if (sts.full)
                    begin
                        cmd.res_ld = 1'b1;
                        if (sts.op == OP_EVENT)
                        begin
                            poison_next    = 1'b1;
                            cmd.res_status = ST_ERR;
                        end
                        else
                        begin
                            cmd.res_status = ST_REJ;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        phase_next = PH_POINT;
                        hstep_next = 2'd0;
                        state_next = S_HSTART;
                    end
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SCMP;
                end
            end
            S_SCMP:
            begin
                if (sts.match)
                begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_disc   = (sts.op == OP_EVENT) && !sts.hit_valid;
                    cmd.res_status = ST_OK;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.srch_inc = 1'b1;
                    state_next   = S_SRD;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_ZERO;
            hstep_reg    <= '0;
            have_agg_reg <= 1'b0;
            poison_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            hstep_reg    <= hstep_next;
            have_agg_reg <= have_agg_next;
            poison_reg   <= poison_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
endmodule
`default_nettype wire

// ===== src/behaviour_map_hash_extend.sv =====
// An item that changes no hash goes through decode and, for events and loads, a linear
// table search (read then compare per entry); each extend adds four SHA-256 compressions,
// and an item can need up to two extends.
// Throughput: one item at a time; the shared one-round-per-cycle SHA-256 core and the
// linear table search set the rate. Reset (rst_n low, async) clears control state,
// measurement, counters and config; table contents are not cleared (fill count only).
`default_nettype none
`include "assert_macros.svh"
module behaviour_map_hash_extend #(
    parameter int MAP_ENTRIES = bmhe_pkg::MAP_ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] point_w0,
    input  wire logic [63:0] point_w1,
    input  wire logic [63:0] point_w2,
    input  wire logic [63:0] point_w3,
    input  wire logic [21:0] proc_id,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             added,
    output logic             discipline_flag,
    output logic [1:0]       status_code,
    output logic [63:0]      measure_w0,
    output logic [63:0]      measure_w1,
    output logic [63:0]      measure_w2,
    output logic [63:0]      measure_w3,
    output logic [21:0]      last_proc_id,
    output logic [8:0]       trajectory_len
);
    import bmhe_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Controller: decode, search loop, extend sequence, poison/aggregate flags.
    bmhe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: table memory, SHA core, measurement and result registers.
    bmhe_datapath #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .op              (op),
        .point_w0        (point_w0),
        .point_w1        (point_w1),
        .point_w2        (point_w2),
        .point_w3        (point_w3),
        .proc_id         (proc_id),
        .added           (added),
        .discipline_flag (discipline_flag),
        .status_code     (status_code),
        .measure_w0      (measure_w0),
        .measure_w1      (measure_w1),
        .measure_w2      (measure_w2),
        .measure_w3      (measure_w3),
        .last_proc_id    (last_proc_id),
        .trajectory_len  (trajectory_len)
    );

    // a transfer in is never followed directly by a result
    `ASSERT_NEXT(a_in_no_out, clk, rst_n, in_valid && !in_stall, !out_valid)
    // one result per item: after an output transfer the channel goes quiet
    `ASSERT_NEXT(a_out_once, clk, rst_n, out_valid && !out_stall, !out_valid)
    // a pending result blocks new input
    `ASSERT_SAME(a_out_blocks_in, clk, rst_n, out_valid, in_stall)
    // trajectory count never goes down
    `ASSERT_NEXT(a_traj_mono, clk, rst_n, 1'b1, trajectory_len >= $past(trajectory_len))
endmodule
`default_nettype wire

// ===== sim/bmhe_checker.sv =====
`default_nettype none
module bmhe_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] point_w0,
    input  wire logic [63:0] point_w1,
    input  wire logic [63:0] point_w2,
    input  wire logic [63:0] point_w3,
    input  wire logic [21:0] proc_id,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        added,
    input  wire logic        discipline_flag,
    input  wire logic [1:0]  status_code,
    input  wire logic [63:0] measure_w0,
    input  wire logic [63:0] measure_w1,
    input  wire logic [63:0] measure_w2,
    input  wire logic [63:0] measure_w3,
    input  wire logic [21:0] last_proc_id,
    input  wire logic [8:0]  trajectory_len,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bmhe_pkg::*;

    localparam int TABLE_DEPTH = MAP_ENTRIES_DEF;

    localparam logic [2047:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [255:0] SHA_IV =
        256'h6a09e667bb67ae853c6ef372a54ff53a510e527f9b05688c1f83d9ab5be0cd19;

    typedef struct packed {
        logic         added;
        logic         disc;
        logic [1:0]   status;
        logic [255:0] meas;
        logic [21:0]  pid;
        logic [8:0]   traj;
    } outcome_t;

    outcome_t     outcome_q[$];

    // shadow of the block's registers and state
    logic [255:0] host_id;
    logic         sealed;
    logic [255:0] point_tbl [TABLE_DEPTH];
    logic         point_ok  [TABLE_DEPTH];
    int           fill;
    logic [255:0] meas;
    logic         agg_set;
    logic         dead;
    logic [8:0]   traj_cnt;
    logic [21:0]  pid_reg;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_round_block(input logic [255:0] h,
                                                     input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, hh} = h;
        for (int i = 0; i < 64; i++)
        begin
            t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[2047 - 32 * i -: 32] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        return {h[255:224] + a, h[223:192] + b, h[191:160] + c, h[159:128] + d,
                h[127:96] + e, h[95:64] + f, h[63:32] + g, h[31:0] + hh};
    endfunction

    // SHA-256 of exactly one 64-byte message
    function automatic logic [255:0] digest64(input logic [511:0] msg);
        return sha_round_block(sha_round_block(SHA_IV, msg),
                               {32'h80000000, 448'd0, 32'd512});
    endfunction

    function automatic void fold_in(input logic [255:0] upd);
        meas = digest64({meas, digest64({host_id, upd})});
    endfunction

    function automatic int lookup(input logic [255:0] p);
        for (int i = 0; i < fill; i++)
            if (point_tbl[i] == p) return i;
        return -1;
    endfunction

    function automatic void remember(input logic [255:0] p, input logic ok);
        point_tbl[fill] = p;
        point_ok[fill] = ok;
        fill++;
    endfunction

    function automatic outcome_t measure_item(input logic [1:0] code,
                                              input logic [255:0] p,
                                              input logic [21:0] pid);
        outcome_t r;
        int hit;
        r = '0;
        r.status = ST_OK;
        if (code == OP_NONE || dead)
            r.status = ST_ERR;
        else if (code == OP_EVENT)
        begin
            if (!agg_set)
            begin
                fold_in(256'd0);
                agg_set = 1'b1;
            end
            pid_reg = pid;
            hit = lookup(p);
            if (hit >= 0)
                r.disc = !point_ok[hit];
            else if (fill >= TABLE_DEPTH)
            begin
                dead = 1'b1;
                r.status = ST_ERR;
            end
            else
            begin
                fold_in(p);
                remember(p, !sealed);
                if (sealed) r.disc = 1'b1;
                else if (traj_cnt != 9'd511) traj_cnt++;
                r.added = 1'b1;
            end
        end
        else if (code == OP_LOAD)
        begin
            if (sealed)
                r.status = ST_REJ;
            else if (lookup(p) < 0)
            begin
                if (fill >= TABLE_DEPTH)
                    r.status = ST_REJ;
                else
                begin
                    fold_in(p);
                    remember(p, 1'b1);
                    r.added = 1'b1;
                end
            end
        end
        else if (agg_set)
        begin
            if (!sealed)
            begin
                dead = 1'b1;
                r.status = ST_ERR;
            end
        end
        else
        begin
            fold_in(p);
            agg_set = 1'b1;
        end
        r.meas = meas;
        r.pid = pid_reg;
        r.traj = traj_cnt;
        return r;
    endfunction

    task automatic report(input string field, input logic [255:0] want, input logic [255:0] got);
        if (errors < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
        errors++;
    endtask

    outcome_t want;
    outcome_t got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_id  = '0;
            sealed   = 1'b0;
            fill     = 0;
            meas     = '0;
            agg_set  = 1'b0;
            dead     = 1'b0;
            traj_cnt = '0;
            pid_reg  = '0;
            outcome_q.delete();
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOST0: host_id[255:192] = cfg_data;
                    REG_HOST1: host_id[191:128] = cfg_data;
                    REG_HOST2: host_id[127:64]  = cfg_data;
                    REG_HOST3: host_id[63:0]    = cfg_data;
                    REG_SEAL:  sealed           = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                outcome_q.push_back(measure_item(op,
                    {point_w0, point_w1, point_w2, point_w3}, proc_id));
            if (out_valid && !out_stall)
            begin
                got = {added, discipline_flag, status_code,
                       measure_w0, measure_w1, measure_w2, measure_w3,
                       last_proc_id, trajectory_len};
                if (outcome_q.size() == 0)
                    report("unexpected transfer", '0, got.meas);
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.added !== want.added)
                        report("added", 256'(want.added), 256'(got.added));
                    if (got.disc !== want.disc)
                        report("discipline_flag", 256'(want.disc), 256'(got.disc));
                    if (got.status !== want.status)
                        report("status_code", 256'(want.status), 256'(got.status));
                    if (got.meas !== want.meas)     report("measurement", want.meas, got.meas);
                    if (got.pid !== want.pid)
                        report("last_proc_id", 256'(want.pid), 256'(got.pid));
                    if (got.traj !== want.traj)
                        report("trajectory_len", 256'(want.traj), 256'(got.traj));
                end
            end
            pending = outcome_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== sim/behaviour_map_hash_extend_tb.sv =====
`default_nettype none
module behaviour_map_hash_extend_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmhe_pkg::*;

    // cycles with no transfer on either side before the run is declared hung;
    // it must exceed the worst item, plus stalls and the final settle time
    localparam int HANG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 1100;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [63:0] point_w0, point_w1, point_w2, point_w3;
    logic [21:0] proc_id;
    logic        out_valid;
    logic        out_stall;
    logic        added;
    logic        discipline_flag;
    logic [1:0]  status_code;
    logic [63:0] measure_w0, measure_w1, measure_w2, measure_w3;
    logic [21:0] last_proc_id;
    logic [8:0]  trajectory_len;

    int          errors;
    int          pending;
    int          quiet_cycles;
    logic        calm;          // no gaps and no stalls while set
    logic [255:0] seen_points[$];

    behaviour_map_hash_extend uut (.*);

    bmhe_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver side: random back-pressure, changed on the falling edge
    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 7);

    // hang detector: counts cycles in which nothing moves on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= HANG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [255:0] any_point();
        return {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [21:0] any_pid();
        return 22'($urandom_range(22'h3fffff));
    endfunction

    // fresh point (remembered for reuse) or one already used
    function automatic logic [255:0] pick_point(input int fresh_pct);
        logic [255:0] p;
        if (seen_points.size() == 0 || $urandom_range(99) < fresh_pct)
        begin
            case ($urandom_range(39))
                0:       p = '0;
                1:       p = '1;
                default: p = any_point();
            endcase
            seen_points.push_back(p);
        end
        else
            p = seen_points[$urandom_range(seen_points.size() - 1)];
        return p;
    endfunction

    // one input transfer; called and returns at a falling edge, valid left high
    task automatic send(input logic [1:0] code, input logic [255:0] p, input logic [21:0] pid);
        if (!calm && $urandom_range(99) < 7)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        op = code;
        {point_w0, point_w1, point_w2, point_w3} = p;
        proc_id = pid;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // register writes only once every result has come back
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_host(input logic [255:0] id);
        write_reg(REG_HOST0, id[255:192]);
        write_reg(REG_HOST1, id[191:128]);
        write_reg(REG_HOST2, id[127:64]);
        write_reg(REG_HOST3, id[63:0]);
    endtask

    logic [255:0] first_pt;
    logic [255:0] sealed_pt;
    int           roll;
    logic [1:0]   code;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_EVENT;
        {point_w0, point_w1, point_w2, point_w3} = '0;
        proc_id = '0;
        out_stall = 1'b0;
        calm = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part
        set_host('1);
        write_reg(REG_SEAL, 64'd0);
        first_pt = 256'd0;
        send(OP_NONE, '1, '1);
        send(OP_EVENT, first_pt, 22'h3fffff);  // no aggregate yet: zero extension first
        send(OP_EVENT, first_pt, 22'd0);       // known valid point
        send(OP_LOAD, '1, 22'h155555);         // new point loaded
        send(OP_LOAD, '1, 22'h2aaaaa);         // known point, ok
        send(OP_LOAD, 256'h1, 22'd1);
        seen_points.push_back(first_pt);
        seen_points.push_back('1);
        set_host('0);
        write_reg(REG_SEAL, 64'd1);
        sealed_pt = {8{32'h5a5aa5a5}};
        send(OP_AGG, '1, 22'd7);               // sealed, aggregate present: no change
        send(OP_LOAD, any_point(), 22'd8);     // sealed: rejected
        send(OP_EVENT, sealed_pt, 22'd9);      // new point while sealed: stored invalid
        send(OP_EVENT, sealed_pt, 22'd10);     // known invalid point raises the flag
        send(OP_EVENT, '1, 22'd11);            // known valid point
        send(OP_NONE, '0, '0);
        seen_points.push_back(sealed_pt);

        // random part: five phases with different host ids and seal settings
        for (int ph = 0; ph < 5; ph++)
        begin
            set_host(ph == 0 ? '1 : any_point());
            write_reg(REG_SEAL, (ph == 2 || ph == 4) ? 64'd1 : 64'd0);
            calm = (ph == 1);
            for (int n = 0; n < 125; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 55)
                    // keep a margin so the table does not fill before the end
                    send(OP_EVENT, pick_point(seen_points.size() < 240 ? 55 : 0),
                         any_pid());
                else if (roll < 88)
                    send(OP_LOAD, pick_point(55), any_pid());
                else if (roll < 94)
                begin
                    // an aggregate while unsealed would poison the block too early
                    code = (ph == 2 || ph == 4) ? OP_AGG : OP_NONE;
                    send(code, any_point(), any_pid());
                end
                else
                    send(OP_NONE, any_point(), any_pid());
            end
        end
        calm = 1'b0;

        // fill the table, overflow it with loads, then an event that poisons
        write_reg(REG_SEAL, 64'd0);
        for (int n = 0; n < 24; n++)
            send(OP_LOAD, any_point(), any_pid());
        send(OP_EVENT, any_point(), 22'h3fffff);
        send(OP_AGG, any_point(), 22'd3);      // unsealed with aggregate: poisons anyway
        send(OP_EVENT, first_pt, 22'd5);
        send(OP_LOAD, any_point(), 22'd6);
        send(OP_AGG, '0, 22'd2);

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
